/* rtl/bbr_pkg.sv */
// ----------------------------------------------------------------------------
// bbr_pkg
// Shared types and constants of the clamped row box filter.
// ----------------------------------------------------------------------------
package bbr_pkg;

  localparam int RADIUS_BITS = 5;
  localparam int POS_BITS    = 16;

  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(1);
  localparam logic [POS_BITS-1:0]    POS_MAX      = {POS_BITS{1'b1}};

  // window sum grows by the log of the widest window (63 samples)
  localparam int SUM_GROWTH = 6;

  // per-beat job control, front to back
  typedef struct packed {
    logic                   row_end;
    logic [POS_BITS-1:0]    pos;
    logic [RADIUS_BITS-1:0] radius;
  } bbr_ctl_t;

endpackage
// ----------------------------------------------------------------------------

/* rtl/bbr_if.sv */
// ----------------------------------------------------------------------------
// bbr_if
// Valid/ready channels of the clamped row box filter.
// ----------------------------------------------------------------------------
interface bbr_in_if #(parameter int SAMPLE_BITS = 16);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   row_end;
  modport source (output valid, output sample, output row_end, input ready);
  modport sink (input valid, input sample, input row_end, output ready);
endinterface

interface bbr_out_if #(parameter int SAMPLE_BITS = 16);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] mean_value;
  logic                   row_done;
  modport source (output valid, output mean_value, output row_done, input ready);
  modport sink (input valid, input mean_value, input row_done, output ready);
endinterface

interface bbr_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] radius;
  modport source (output valid, output radius, input ready);
  modport sink (input valid, input radius, output ready);
endinterface
// ----------------------------------------------------------------------------

/* rtl/bbr_fifo.sv */
// ----------------------------------------------------------------------------
// bbr_fifo
// Small register queue between the front and the back part.
// ----------------------------------------------------------------------------
module bbr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
// ----------------------------------------------------------------------------

/* rtl/bbr_front.sv */
// ----------------------------------------------------------------------------
// bbr_front
// Accepts sample beats, tracks row position and first sample, holds radius.
// ----------------------------------------------------------------------------
module bbr_front import bbr_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_RADIUS  = 31
) (
  input  logic                   clk,
  input  logic                   rst,
  bbr_in_if.sink                 pixel_in,
  bbr_cfg_if.sink                cfg,
  input  logic                   q_full,
  output logic                   push,
  output bbr_ctl_t               push_ctl,
  output logic [SAMPLE_BITS-1:0] push_sample,
  output logic [SAMPLE_BITS-1:0] push_first
);

  logic [RADIUS_BITS-1:0] radius;
  logic [RADIUS_BITS-1:0] radius_eff;
  logic [POS_BITS-1:0]    pos;
  logic [SAMPLE_BITS-1:0] first;

  assign cfg.ready      = 1'b1;
  assign pixel_in.ready = !q_full;
  assign push           = pixel_in.valid && !q_full;

  assign radius_eff = (int'(radius) > MAX_RADIUS) ? RADIUS_BITS'(MAX_RADIUS) : radius;

  assign push_sample      = pixel_in.sample;
  assign push_first       = (pos == '0) ? pixel_in.sample : first;
  assign push_ctl.row_end = pixel_in.row_end;
  assign push_ctl.pos     = pos;
  assign push_ctl.radius  = radius_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
      pos    <= '0;
      first  <= '0;
    end else if (cfg.valid) begin
      radius <= cfg.radius;
      pos    <= '0;
      first  <= '0;
    end else if (push) begin
      first <= push_first;
      if (pixel_in.row_end) begin
        pos <= '0;
      end else if (pos != POS_MAX) begin
        pos <= pos + 1'b1;
      end
    end
  end

endmodule
// ----------------------------------------------------------------------------

/* rtl/bbr_accum.sv */
// ----------------------------------------------------------------------------
// bbr_accum
// Back part: sample store and window sum sequencer, one tap per cycle.
// ----------------------------------------------------------------------------
module bbr_accum import bbr_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_RADIUS  = 31
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              job_valid,
  output logic                              job_ready,
  input  bbr_ctl_t                          job_ctl,
  input  logic [SAMPLE_BITS-1:0]            job_sample,
  input  logic [SAMPLE_BITS-1:0]            job_first,
  output logic                              dv_valid,
  input  logic                              dv_ready,
  output logic [SAMPLE_BITS+SUM_GROWTH-1:0] dv_dividend,
  output logic [RADIUS_BITS:0]              dv_divisor,
  output logic                              dv_last
);

  localparam int SUM_BITS = SAMPLE_BITS + SUM_GROWTH;
  localparam int DEPTH    = 2 ** $clog2(2 * MAX_RADIUS + 2);
  localparam int AW       = $clog2(DEPTH);
  localparam int DW       = RADIUS_BITS + 3;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SUM  = 2'd1;
  localparam logic [1:0] S_SEND = 2'd2;

  localparam logic [1:0] SEL_NEW   = 2'd0;
  localparam logic [1:0] SEL_FIRST = 2'd1;
  localparam logic [1:0] SEL_MEM   = 2'd2;

  logic [SAMPLE_BITS-1:0] mem [DEPTH];

  logic [1:0]             state;
  bbr_ctl_t               ctl;
  logic [SAMPLE_BITS-1:0] smp;
  logic [SAMPLE_BITS-1:0] fst;
  logic [AW-1:0]          wp;
  logic [AW-1:0]          base;
  logic [RADIUS_BITS-1:0] t;
  logic [RADIUS_BITS:0]   k;
  logic                   iss;
  logic                   p_vld;
  logic                   p_last;
  logic [1:0]             p_sel;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [SUM_BITS-1:0]    acc;

  logic signed [DW-1:0]   d;
  logic [1:0]             sel;
  logic [AW-1:0]          rd_addr;
  logic [RADIUS_BITS:0]   two_r;
  logic [SAMPLE_BITS-1:0] tap;
  logic                   job_take;
  logic                   job_emits;

  assign two_r = {ctl.radius, 1'b0};
  assign d = signed'({3'b000, t}) + signed'({3'b000, ctl.radius})
           - signed'({2'b00, k});
  assign rd_addr = base - d[AW-1:0];

  always_comb begin
    if (d[DW-1] || d == '0) begin
      sel = SEL_NEW;
    end else if ({{(POS_BITS-DW){1'b0}}, d} > ctl.pos) begin
      sel = SEL_FIRST;
    end else begin
      sel = SEL_MEM;
    end
  end

  always_comb begin
    case (p_sel)
      SEL_NEW:   tap = smp;
      SEL_FIRST: tap = fst;
      default:   tap = rd_data;
    endcase
  end

  assign job_ready = (state == S_IDLE);
  assign job_take  = job_valid && job_ready;
  assign job_emits = job_ctl.row_end
                  || (job_ctl.pos >= {{(POS_BITS-RADIUS_BITS){1'b0}}, job_ctl.radius});

  assign dv_valid    = (state == S_SEND);
  assign dv_dividend = acc + SUM_BITS'(ctl.radius);
  assign dv_divisor  = {ctl.radius, 1'b1};
  assign dv_last     = ctl.row_end && (t == '0);

  always_ff @(posedge clk) begin
    if (job_take) begin
      mem[wp] <= job_sample;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      ctl  <= job_ctl;
      smp  <= job_sample;
      fst  <= job_first;
      base <= wp;
      if (job_ctl.pos < {{(POS_BITS-RADIUS_BITS){1'b0}}, job_ctl.radius}) begin
        t <= job_ctl.pos[RADIUS_BITS-1:0];
      end else begin
        t <= job_ctl.radius;
      end
    end else if (state == S_SEND && dv_ready && !dv_last && ctl.row_end) begin
      t <= t - 1'b1;
    end
    p_sel <= sel;
    if (p_vld) begin
      acc <= acc + SUM_BITS'(tap);
    end else if (state == S_IDLE || (state == S_SEND && dv_ready)) begin
      acc <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      wp     <= '0;
      k      <= '0;
      iss    <= 1'b0;
      p_vld  <= 1'b0;
      p_last <= 1'b0;
    end else begin
      p_vld  <= iss;
      p_last <= iss && (k == two_r);
      if (iss) begin
        k <= k + 1'b1;
        if (k == two_r) begin
          iss <= 1'b0;
        end
      end
      case (state)
        S_IDLE: begin
          if (job_take) begin
            wp <= wp + 1'b1;
            if (job_emits) begin
              state <= S_SUM;
              k     <= '0;
              iss   <= 1'b1;
            end
          end
        end
        S_SUM: begin
          if (p_vld && p_last) begin
            state <= S_SEND;
          end
        end
        S_SEND: begin
          if (dv_ready) begin
            if (ctl.row_end && !dv_last) begin
              state <= S_SUM;
              k     <= '0;
              iss   <= 1'b1;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
// ----------------------------------------------------------------------------

/* rtl/bbr_div.sv */
// ----------------------------------------------------------------------------
// bbr_div
// Back part: bit-serial restoring divider with output register.
// ----------------------------------------------------------------------------
module bbr_div import bbr_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              dv_valid,
  output logic                              dv_ready,
  input  logic [SAMPLE_BITS+SUM_GROWTH-1:0] dv_dividend,
  input  logic [RADIUS_BITS:0]              dv_divisor,
  input  logic                              dv_last,
  bbr_out_if.source                         pixel_out
);

  localparam int N  = SAMPLE_BITS + SUM_GROWTH;
  localparam int CW = $clog2(N + 1);
  localparam int RB = RADIUS_BITS + 1;

  logic                   busy;
  logic [CW-1:0]          cnt;
  logic [N-1:0]           dvd;
  logic [N-1:0]           quo;
  logic [RB-1:0]          rem;
  logic [RB-1:0]          dsr;
  logic                   lst;
  logic                   ov;
  logic [SAMPLE_BITS-1:0] mean;
  logic                   done;

  logic [RB:0]            rs;
  logic                   ge;
  logic                   finish;

  assign rs     = {rem, dvd[N-1]};
  assign ge     = (rs >= {1'b0, dsr});
  assign finish = busy && (cnt == '0) && (!ov || pixel_out.ready);

  assign dv_ready             = !busy;
  assign pixel_out.valid      = ov;
  assign pixel_out.mean_value = mean;
  assign pixel_out.row_done   = done;

  always_ff @(posedge clk) begin
    if (dv_valid && dv_ready) begin
      dvd <= dv_dividend;
      dsr <= dv_divisor;
      rem <= '0;
      quo <= '0;
      lst <= dv_last;
    end else if (busy && cnt != '0) begin
      rem <= ge ? RB'(rs - {1'b0, dsr}) : RB'(rs);
      dvd <= {dvd[N-2:0], 1'b0};
      quo <= {quo[N-2:0], ge};
    end
    if (finish) begin
      mean <= quo[SAMPLE_BITS-1:0];
      done <= lst;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      ov   <= 1'b0;
    end else begin
      if (dv_valid && dv_ready) begin
        busy <= 1'b1;
        cnt  <= CW'(N);
      end else if (busy && cnt != '0) begin
        cnt <= cnt - 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (finish) begin
        ov <= 1'b1;
      end else if (ov && pixel_out.ready) begin
        ov <= 1'b0;
      end
    end
  end

endmodule
// ----------------------------------------------------------------------------

/* rtl/box_blur_row_clamped.sv */
// ----------------------------------------------------------------------------
// box_blur_row_clamped
// Horizontal box mean over one row, edges replicated, rounded half up.
//
//   channel    dir  payload                    beat taken when
//   pixel_in   in   sample, row_end            valid & ready
//   pixel_out  out  mean_value, row_done       valid & ready
//   cfg        in   radius                     valid & ready (always ready)
//
// Each result sums 2r+1 taps, one store read per cycle, then a restoring
// divider turns the sum into the mean; the divider overlaps the next sum,
// also within a row-end flush.
// A two-entry queue decouples input from the sum sequencer.
// rst is synchronous; it sets radius to 1 and starts a new row.
// A full output register stalls the divider, then the sequencer, then input.
// ----------------------------------------------------------------------------
module box_blur_row_clamped import bbr_pkg::*; #(
  parameter int MAX_RADIUS  = 31,
  parameter int SAMPLE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  bbr_in_if.sink     pixel_in,
  bbr_out_if.source  pixel_out,
  bbr_cfg_if.sink    cfg
);

  localparam int QW = 2 * SAMPLE_BITS + $bits(bbr_ctl_t);

  logic                              push;
  bbr_ctl_t                          push_ctl;
  logic [SAMPLE_BITS-1:0]            push_sample;
  logic [SAMPLE_BITS-1:0]            push_first;
  logic                              q_full;
  logic [QW-1:0]                     q_out;
  logic                              q_valid;
  logic                              q_pop;
  bbr_ctl_t                          job_ctl;
  logic [SAMPLE_BITS-1:0]            job_sample;
  logic [SAMPLE_BITS-1:0]            job_first;
  logic                              job_ready;
  logic                              dv_valid;
  logic                              dv_ready;
  logic [SAMPLE_BITS+SUM_GROWTH-1:0] dv_dividend;
  logic [RADIUS_BITS:0]              dv_divisor;
  logic                              dv_last;

  bbr_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_RADIUS  (MAX_RADIUS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel_in    (pixel_in),
    .cfg         (cfg),
    .q_full      (q_full),
    .push        (push),
    .push_ctl    (push_ctl),
    .push_sample (push_sample),
    .push_first  (push_first)
  );

  bbr_fifo #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_ctl, push_sample, push_first}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .not_empty (q_valid)
  );

  assign {job_ctl, job_sample, job_first} = q_out;
  assign q_pop = q_valid && job_ready;

  bbr_accum #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_RADIUS  (MAX_RADIUS)
  ) u_accum (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (q_valid),
    .job_ready   (job_ready),
    .job_ctl     (job_ctl),
    .job_sample  (job_sample),
    .job_first   (job_first),
    .dv_valid    (dv_valid),
    .dv_ready    (dv_ready),
    .dv_dividend (dv_dividend),
    .dv_divisor  (dv_divisor),
    .dv_last     (dv_last)
  );

  bbr_div #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk         (clk),
    .rst         (rst),
    .dv_valid    (dv_valid),
    .dv_ready    (dv_ready),
    .dv_dividend (dv_dividend),
    .dv_divisor  (dv_divisor),
    .dv_last     (dv_last),
    .pixel_out   (pixel_out)
  );

endmodule
// ----------------------------------------------------------------------------

/* tb/tb_box_blur_row_clamped.sv */
// ----------------------------------------------------------------------------
// tb_box_blur_row_clamped
// Self-checking bench for the clamped row box filter. Rows of pixels go in
// over a valid/ready channel; a local model of the window, first sample and
// row position predicts every rounded mean and row-done flag. Each output
// beat is matched against the oldest prediction. The run covers directed
// edge rows, radius changes between and inside rows, random rows under
// random stalls on both sides, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module tb_box_blur_row_clamped;
  import bbr_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int QUIET_CYCLES = 400;
  localparam int HOLD_CYCLES  = 800;

  typedef struct packed {
    logic [15:0] mean_value;
    logic        row_done;
  } pixel_mean_t;

  logic clk;
  logic rst;

  bbr_in_if  #(.SAMPLE_BITS(16)) pix_in_ch ();
  bbr_out_if #(.SAMPLE_BITS(16)) pix_out_ch ();
  bbr_cfg_if                     cfg_ch ();

  box_blur_row_clamped #(
    .MAX_RADIUS  (31),
    .SAMPLE_BITS (16)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (pix_in_ch),
    .pixel_out (pix_out_ch),
    .cfg       (cfg_ch)
  );

  pixel_mean_t pending_means[$];
  pixel_mean_t want;

  logic [15:0]            win_mem [64];
  logic [5:0]             wr_ptr;
  logic [15:0]            row_first;
  logic [15:0]            row_pos;
  logic [RADIUS_BITS-1:0] blur_radius;

  int  src_idle_pct;
  int  snk_idle_pct;
  int  items_sent;
  int  mismatches;
  int  cycle_count;
  logic hold_rx;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    pix_out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst || hold_rx) begin
        pix_out_ch.ready <= 1'b0;
      end else begin
        pix_out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pix_out_ch.valid && pix_out_ch.ready) begin
      if (pending_means.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected beat: mean %0d row_done %0b",
                   pix_out_ch.mean_value, pix_out_ch.row_done);
        end
      end else begin
        want = pending_means.pop_front();
        if (pix_out_ch.mean_value !== want.mean_value ||
            pix_out_ch.row_done !== want.row_done) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected mean %0d row_done %0b, got mean %0d row_done %0b",
                     want.mean_value, want.row_done,
                     pix_out_ch.mean_value, pix_out_ch.row_done);
          end
        end
      end
    end
  end

  task automatic predict_row_means(input logic [15:0] s, input logic e);
    int r;
    int t;
    int k;
    int d;
    int pos;
    int unsigned acc;
    pixel_mean_t res;
    r   = blur_radius;
    pos = row_pos;
    if (pos == 0) row_first = s;
    win_mem[wr_ptr] = s;
    for (t = r; t >= 0; t--) begin
      if (t > pos) continue;
      if (!e && t != r) break;
      acc = 0;
      for (k = -r; k <= r; k++) begin
        d = t - k;
        if (d < 0) begin
          acc += s;
        end else if (d > pos) begin
          acc += row_first;
        end else begin
          acc += win_mem[6'(wr_ptr - 6'(d))];
        end
      end
      res.mean_value = 16'((acc + r) / (2 * r + 1));
      res.row_done   = e && (t == 0);
      pending_means.push_back(res);
    end
    wr_ptr = wr_ptr + 6'd1;
    if (e) begin
      row_pos = '0;
    end else if (row_pos != POS_MAX) begin
      row_pos = row_pos + 16'd1;
    end
  endtask

  task automatic send_pixel(input logic [15:0] s, input logic e);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in_ch.valid   <= 1'b1;
    pix_in_ch.sample  <= s;
    pix_in_ch.row_end <= e;
    @(posedge clk);
    while (!pix_in_ch.ready) @(posedge clk);
    predict_row_means(s, e);
    items_sent++;
  endtask

  function automatic logic [15:0] rand_sample();
    int pick;
    pick = $urandom_range(7);
    if (pick == 0) return 16'h0000;
    if (pick == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic send_row(input int len, input bit close);
    int i;
    for (i = 0; i < len; i++) begin
      send_pixel(rand_sample(), close && (i == len - 1));
    end
  endtask

  task automatic drain_results();
    pix_in_ch.valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_radius(input logic [RADIUS_BITS-1:0] r);
    drain_results();
    cfg_ch.valid  <= 1'b1;
    cfg_ch.radius <= r;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    blur_radius = r;
    row_first   = '0;
    row_pos     = '0;
  endtask

  task automatic test_default_radius();
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b1);
  endtask

  task automatic test_radius_extremes();
    write_radius(5'd0);
    send_pixel(16'h0001, 1'b0);
    send_pixel(16'hFFFE, 1'b1);
    write_radius(5'd31);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h8001, 1'b1);
  endtask

  task automatic test_mid_row_restart();
    write_radius(5'd2);
    send_row(3, 1'b1);
    send_pixel(16'h1234, 1'b0);
    send_pixel(16'hEDCB, 1'b0);
    write_radius(5'd3);
    send_row(4, 1'b1);
  endtask

  task automatic test_backpressure_hold();
    write_radius(5'd4);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    fork
      begin
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
      end
    join_none
    send_row(40, 1'b1);
    drain_results();
  endtask

  task automatic test_drain_pause();
    src_idle_pct = 37;
    snk_idle_pct = 79;
    write_radius(5'd3);
    send_row(8, 1'b0);
    drain_results();
    send_row(6, 1'b1);
  endtask

  task automatic run_random_rows(input int src_pct, input int snk_pct, input int n_items);
    int stop_at;
    int r;
    int len;
    bit close;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    stop_at = items_sent + n_items;
    close = 1'b1;
    while (items_sent < stop_at) begin
      if (!close || $urandom_range(3) == 0) begin
        case ($urandom_range(7))
          0:       r = 31;
          1:       r = $urandom_range(31);
          default: r = $urandom_range(6);
        endcase
        write_radius(5'(r));
      end
      r = blur_radius;
      if ($urandom_range(5) == 0 && r < 8) begin
        len = $urandom_range(60, 90);
      end else begin
        len = $urandom_range(1, 2 * r + 4);
      end
      if (len > stop_at - items_sent) begin
        len = stop_at - items_sent;
      end
      close = ($urandom_range(9) != 0);
      send_row(len, close);
    end
    drain_results();
  endtask

  task automatic test_random_rows();
    run_random_rows(37, 79, 18);
    run_random_rows(79, 37, 18);
    run_random_rows(0, 0, 18);
  endtask

  initial begin
    rst               = 1'b1;
    hold_rx           = 1'b0;
    pix_in_ch.valid   = 1'b0;
    pix_in_ch.sample  = '0;
    pix_in_ch.row_end = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.radius     = '0;
    src_idle_pct      = 37;
    snk_idle_pct      = 79;
    items_sent        = 0;
    mismatches        = 0;
    wr_ptr            = '0;
    row_first         = '0;
    row_pos           = '0;
    blur_radius       = RADIUS_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_radius();
    test_radius_extremes();
    test_mid_row_restart();
    test_backpressure_hold();
    test_drain_pause();
    test_random_rows();

    drain_results();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
// ----------------------------------------------------------------------------

/* box_blur_row_clamped.f */
rtl/bbr_pkg.sv
rtl/bbr_if.sv
rtl/bbr_fifo.sv
rtl/bbr_front.sv
rtl/bbr_accum.sv
rtl/bbr_div.sv
rtl/box_blur_row_clamped.sv
tb/tb_box_blur_row_clamped.sv
